@@ hw/rtl/box_blur_3x3_edge_normalized_defines.svh @@
// assertion macros shared by the box blur rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef BOX_BLUR_3X3_EDGE_NORMALIZED_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_NORMALIZED_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge out of reset
`define BBN_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// implication from one cycle to the next
`define BBN_ASSERT_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`else

`define BBN_ASSERT(name, expr, msg)
`define BBN_ASSERT_NEXT(name, cond, expr, msg)

`endif

`endif

@@ hw/rtl/bbn_pkg.sv @@
// shared types, constants and divide helpers for the box blur
// no dependencies
`timescale 1ns / 1ps

package bbn_pkg;

    localparam int SIZE_W        = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int PIX_W         = 24;
    localparam int SUM_W         = 12;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int RECIP_W       = 14;
    localparam int RECIP_SHIFT   = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    // neighbor count codes
    localparam logic [1:0] NDIV_4 = 2'd0;
    localparam logic [1:0] NDIV_6 = 2'd1;
    localparam logic [1:0] NDIV_9 = 2'd2;

    // which neighbors the output pixel takes
    typedef struct packed {
        logic emit;
        logic eof;
        logic use_top;
        logic use_bot;
        logic use_left;
        logic use_right;
    } bbn_tap_t;

    // window sums handed to the normalizer
    typedef struct packed {
        logic             eof;
        logic [1:0]       ncode;
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } bbn_sum_t;

    function automatic logic [3:0] ndiv_count(input logic [1:0] code);
        logic [3:0] n;
        case (code)
            NDIV_4:  n = 4'd4;
            NDIV_6:  n = 4'd6;
            NDIV_9:  n = 4'd9;
            default: n = 4'd4;
        endcase
        return n;
    endfunction

    // ceil(2^16 / (2n)), exact for numerators up to 2*2295+9
    function automatic logic [RECIP_W-1:0] ndiv_recip(input logic [1:0] code);
        logic [RECIP_W-1:0] k;
        case (code)
            NDIV_4:  k = 14'd8192;
            NDIV_6:  k = 14'd5462;
            NDIV_9:  k = 14'd3641;
            default: k = 14'd8192;
        endcase
        return k;
    endfunction

endpackage

@@ hw/rtl/bbn_ctrl.sv @@
// raster position, frame size registers and input handshake
// depends on bbn_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "box_blur_3x3_edge_normalized_defines.svh"

module bbn_ctrl
    import bbn_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [SIZE_W-1:0]             cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic                          s1_ready,
    output logic                          take,
    output logic [$clog2(MAX_WIDTH)-1:0]  col,
    output bbn_tap_t                      tap
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CMP_W  = (ADDR_W > SIZE_W) ? ADDR_W : SIZE_W;
    localparam int ROW_W  = SIZE_W + 1;
    localparam int LIM_W  = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
    localparam int LIM_H  = (MAX_HEIGHT < 2047) ? MAX_HEIGHT : 2047;
    localparam int RST_W  = (LIM_W < 640) ? LIM_W : 640;
    localparam int RST_H  = (LIM_H < 480) ? LIM_H : 480;

    logic [SIZE_W-1:0] w_reg, w_next;
    logic [SIZE_W-1:0] h_reg, h_next;
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              draining_reg, draining_next;

    logic [CMP_W-1:0]  col_ext;
    logic [CMP_W-1:0]  w_ext;
    logic [ROW_W-1:0]  h_ext;
    logic              case_a;
    logic              case_b;
    logic              last_col;
    logic              last_pixel;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v < SIZE_W'(2))
            r = SIZE_W'(2);
        else if (v > lim)
            r = lim;
        else
            r = v;
        return r;
    endfunction

    assign in_stall = !s1_ready;
    assign take     = in_valid && s1_ready && (command == draining_reg);
    assign col      = col_reg;

    assign col_ext  = CMP_W'(col_reg);
    assign w_ext    = CMP_W'(w_reg);
    assign h_ext    = ROW_W'(h_reg);
    assign last_col = (col_ext == w_ext - CMP_W'(1));

    // first column of row r closes row r-2; later columns close row r-1
    assign case_a = (col_reg == '0) && (row_reg >= ROW_W'(2));
    assign case_b = (col_reg != '0) && (row_reg >= ROW_W'(1));

    always_comb
    begin
        tap.emit      = case_a || case_b;
        tap.eof       = case_a && (row_reg == h_ext + ROW_W'(1));
        tap.use_top   = case_a ? (row_reg >= ROW_W'(3)) : (row_reg >= ROW_W'(2));
        tap.use_bot   = case_a ? (row_reg <= h_ext) : (row_reg < h_ext);
        tap.use_left  = case_a || (col_reg >= ADDR_W'(2));
        tap.use_right = case_b;
    end

    assign last_pixel = !draining_reg && (row_reg == h_ext - ROW_W'(1)) && last_col;

    always_comb
    begin
        w_next        = w_reg;
        h_next        = h_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        draining_next = draining_reg;
        if (cfg_write_en && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT))
        begin
            if (cfg_index == CFG_FRAME_WIDTH)
                w_next = clamp_size(cfg_data, SIZE_W'(LIM_W));
            else
                h_next = clamp_size(cfg_data, SIZE_W'(LIM_H));
            col_next      = '0;
            row_next      = '0;
            draining_next = 1'b0;
        end
        else if (take)
        begin
            if (tap.eof)
            begin
                col_next      = '0;
                row_next      = '0;
                draining_next = 1'b0;
            end
            else
            begin
                if (last_pixel)
                    draining_next = 1'b1;
                if (last_col)
                begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                end
                else
                begin
                    col_next = col_reg + ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg        <= SIZE_W'(RST_W);
            h_reg        <= SIZE_W'(RST_H);
            col_reg      <= '0;
            row_reg      <= '0;
            draining_reg <= 1'b0;
        end
        else
        begin
            w_reg        <= w_next;
            h_reg        <= h_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            draining_reg <= draining_next;
        end
    end

    `BBN_ASSERT(a_col_in_frame, col_ext < w_ext, "column counter ran past frame width")
    `BBN_ASSERT(a_drain_row, draining_reg == (row_reg >= h_ext), "drain flag out of step with row")
    `BBN_ASSERT(a_eof_drain, !(take && tap.eof) || draining_reg, "frame end outside drain phase")

endmodule

@@ hw/rtl/bbn_line_mem.sv @@
// line store: upper and middle rows side by side in one memory
// depends on bbn_pkg
`timescale 1ns / 1ps

module bbn_line_mem
    import bbn_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
    output logic [2*PIX_W-1:0]           rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    input  logic [2*PIX_W-1:0]           wr_data
);

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/bbn_window.sv @@
// read-modify-write stage: line store write back, window shift, neighbor sums
// depends on bbn_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "box_blur_3x3_edge_normalized_defines.svh"

module bbn_window
    import bbn_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  bbn_tap_t                     tap,
    input  logic [PIX_W-1:0]             pix_in,
    input  logic [$clog2(MAX_WIDTH)-1:0] addr,
    output logic                         s1_ready,
    input  logic [2*PIX_W-1:0]           rd_data,
    output logic                         wr_en,
    output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
    output logic [2*PIX_W-1:0]           wr_data,
    input  logic                         s2_ready,
    output logic                         sum_valid,
    output bbn_sum_t                     sum
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    logic              s1_valid_reg;
    bbn_tap_t          s1_tap_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [PIX_W-1:0]  win_l_reg [3];
    logic [PIX_W-1:0]  win_c_reg [3];

    logic              s1_move;
    logic [PIX_W-1:0]  pix_a [3][3];
    logic [2:0]        col_en;
    logic [2:0]        row_en;
    logic [SUM_W-1:0]  sum_r, sum_g, sum_b;
    logic              rows3, cols3;

    assign s1_move  = s1_valid_reg && (!s1_tap_reg.emit || s2_ready);
    assign s1_ready = !s1_valid_reg || s1_move;

    // upper takes old middle, middle takes the new pixel
    assign wr_en   = s1_move;
    assign wr_addr = s1_addr_reg;
    assign wr_data = {rd_data[PIX_W-1:0], s1_pix_reg};

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            pix_a[0][r] = win_l_reg[r];
            pix_a[1][r] = win_c_reg[r];
        end
        pix_a[2][0] = rd_data[2*PIX_W-1:PIX_W];
        pix_a[2][1] = rd_data[PIX_W-1:0];
        pix_a[2][2] = s1_pix_reg;
    end

    assign col_en = {s1_tap_reg.use_right, 1'b1, s1_tap_reg.use_left};
    assign row_en = {s1_tap_reg.use_bot, 1'b1, s1_tap_reg.use_top};

    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (col_en[c] && row_en[r])
                begin
                    sum_r = sum_r + SUM_W'(pix_a[c][r][23:16]);
                    sum_g = sum_g + SUM_W'(pix_a[c][r][15:8]);
                    sum_b = sum_b + SUM_W'(pix_a[c][r][7:0]);
                end
            end
        end
    end

    assign rows3 = s1_tap_reg.use_top && s1_tap_reg.use_bot;
    assign cols3 = s1_tap_reg.use_left && s1_tap_reg.use_right;

    assign sum_valid = s1_move && s1_tap_reg.emit;
    always_comb
    begin
        sum.eof   = s1_tap_reg.eof;
        sum.ncode = {1'b0, rows3} + {1'b0, cols3};
        sum.red   = sum_r;
        sum.green = sum_g;
        sum.blue  = sum_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take && s1_ready)
        begin
            s1_tap_reg  <= tap;
            s1_pix_reg  <= pix_in;
            s1_addr_reg <= addr;
        end
        if (s1_move)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_l_reg[r] <= win_c_reg[r];
                win_c_reg[r] <= pix_a[2][r];
            end
        end
    end

    `BBN_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_move, s1_valid_reg && $stable(s1_addr_reg), "stalled line store request moved")
    `BBN_ASSERT(a_two_cols, !sum_valid || s1_tap_reg.use_left || s1_tap_reg.use_right, "blur window narrower than two columns")
    `BBN_ASSERT(a_take_ready, !take || s1_ready, "pixel taken with stage busy")

endmodule

@@ hw/rtl/bbn_norm.sv @@
// rounded divide of window sums by neighbor count and result register
// depends on bbn_pkg
`timescale 1ns / 1ps

module bbn_norm
    import bbn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       sum_valid,
    input  bbn_sum_t   sum,
    output logic       s2_ready,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_red,
    output logic [7:0] out_green,
    output logic [7:0] out_blue,
    output logic       end_of_frame
);

    localparam int NUM_W  = SUM_W + 1;
    localparam int PROD_W = NUM_W + RECIP_W;

    logic               s2_valid_reg;
    bbn_sum_t           s2_sum_reg;
    logic               out_valid_reg;
    logic [7:0]         red_reg, green_reg, blue_reg;
    logic               eof_reg;

    logic               out_ready;
    logic [3:0]         n;
    logic [RECIP_W-1:0] k;
    logic [PROD_W-1:0]  prod_r, prod_g, prod_b;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;

    assign n = ndiv_count(s2_sum_reg.ncode);
    assign k = ndiv_recip(s2_sum_reg.ncode);

    // (2s + n) / 2n by reciprocal multiply
    assign prod_r = PROD_W'({s2_sum_reg.red, 1'b0} + NUM_W'(n)) * PROD_W'(k);
    assign prod_g = PROD_W'({s2_sum_reg.green, 1'b0} + NUM_W'(n)) * PROD_W'(k);
    assign prod_b = PROD_W'({s2_sum_reg.blue, 1'b0} + NUM_W'(n)) * PROD_W'(k);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
                s2_valid_reg <= sum_valid;
            if (out_ready)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && sum_valid)
            s2_sum_reg <= sum;
        if (out_ready && s2_valid_reg)
        begin
            red_reg   <= prod_r[RECIP_SHIFT +: 8];
            green_reg <= prod_g[RECIP_SHIFT +: 8];
            blue_reg  <= prod_b[RECIP_SHIFT +: 8];
            eof_reg   <= s2_sum_reg.eof;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_red      = red_reg;
    assign out_green    = green_reg;
    assign out_blue     = blue_reg;
    assign end_of_frame = eof_reg;

endmodule

@@ hw/rtl/box_blur_3x3_edge_normalized.sv @@
// top level of the streaming 3x3 box blur
// depends on bbn_pkg, bbn_ctrl, bbn_line_mem, bbn_window, bbn_norm
`timescale 1ns / 1ps

// streaming 3x3 box blur of rgb pixels in raster order, averaged over the
// neighbors that lie inside the frame (4 at corners, 6 on edges, 9 inside),
// rounded half up per channel. the block takes one request per clock while
// out_stall is low and keeps that rate indefinitely: the line store is one
// memory with one read and one write port, read when a request enters and
// written back when it leaves the first stage. within a frame no two
// requests touch the same entry back to back; at a frame boundary the first
// column is reused back to back, but the stale value read there only fills
// rows above the new frame and never reaches a result. a result passes the
// first stage, the sum register and the result register after the request
// that closes its window; in the stream that is one row plus one pixel after
// the pixel itself, so after the last pixel of a frame send frame_width + 1
// flush requests (command = 1) to drain it. pixels are dropped while
// draining and flushes are dropped otherwise. end_of_frame marks the last
// pixel of the frame and the next request starts a new frame. frame_width
// and frame_height are clamped to [2, MAX_WIDTH] and [2, 1024]; writing
// either restarts the frame, so write them only while the block is idle.
// out_stall backs up through a result register, a sum register and the
// memory stage before the input stalls.
module box_blur_3x3_edge_normalized
    import bbn_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    // request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [7:0]           in_red,
    input  logic [7:0]           in_green,
    input  logic [7:0]           in_blue,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_red,
    output logic [7:0]           out_green,
    output logic [7:0]           out_blue,
    output logic                 end_of_frame
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    logic               take;
    logic [ADDR_W-1:0]  col;
    bbn_tap_t           tap;
    logic               s1_ready;
    logic [PIX_W-1:0]   pix_in;
    logic [2*PIX_W-1:0] rd_data;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [2*PIX_W-1:0] wr_data;
    logic               s2_ready;
    logic               sum_valid;
    bbn_sum_t           sum;

    // flush requests push a zero pixel into the line store
    assign pix_in = command ? '0 : {in_red, in_green, in_blue};

    // position tracking, frame size and neighbor selection
    bbn_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .s1_ready     (s1_ready),
        .take         (take),
        .col          (col),
        .tap          (tap)
    );

    // two previous rows, read on entry
    bbn_line_mem #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (take),
        .rd_addr (col),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // write back, column shift and neighbor sums
    bbn_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .tap       (tap),
        .pix_in    (pix_in),
        .addr      (col),
        .s1_ready  (s1_ready),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .s2_ready  (s2_ready),
        .sum_valid (sum_valid),
        .sum       (sum)
    );

    // rounded average and result register
    bbn_norm u_norm (
        .clk          (clk),
        .rst_n        (rst_n),
        .sum_valid    (sum_valid),
        .sum          (sum),
        .s2_ready     (s2_ready),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .end_of_frame (end_of_frame)
    );

endmodule

@@ sim/tb_box_blur_3x3_edge_normalized.sv @@
// self-checking testbench for the streaming 3x3 box blur
// depends on bbn_pkg and box_blur_3x3_edge_normalized; holds its own blur predictor
`timescale 1ns / 1ps

// one blurred output pixel as it leaves the block
typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eof;
} blurred_pixel_t;

// tracks frame position, line stores and window, and queues the blurred pixels due
class blur_tracker;
    bit [23:0]      upper_row [bbn_pkg::MAX_WIDTH_DEF];
    bit [23:0]      middle_row [bbn_pkg::MAX_WIDTH_DEF];
    bit [23:0]      win [3][3];     // [column][top, middle, bottom]
    int             col;
    int             row;
    int             out_count;
    bit             draining;
    bit [10:0]      width_reg;
    bit [10:0]      height_reg;
    blurred_pixel_t expected_pixels[$];
    int             mismatches;
    int             checked;
    int             frames;
    int             accepted;

    function new();
        width_reg  = 11'd640;
        height_reg = 11'd480;
        mismatches = 0;
        checked    = 0;
        frames     = 0;
        accepted   = 0;
        restart_frame();
    endfunction

    function void restart_frame();
        col       = 0;
        row       = 0;
        out_count = 0;
        draining  = 1'b0;
    endfunction

    function int clamp_size(bit [10:0] v, int biggest);
        if (v < 2) return 2;
        if (v > biggest) return biggest;
        return v;
    endfunction

    function void write_register(logic [bbn_pkg::CFG_IDX_W-1:0] idx,
                                 logic [bbn_pkg::SIZE_W-1:0] data);
        if (idx == bbn_pkg::CFG_FRAME_WIDTH) width_reg = data;
        else if (idx == bbn_pkg::CFG_FRAME_HEIGHT) height_reg = data;
        else return;
        restart_frame();
    endfunction

    // mean of the in-frame neighbors around window column ci, frame position (cr, cc)
    function blurred_pixel_t blur_window(int ci, int cr, int cc, int w, int h);
        blurred_pixel_t px;
        bit [23:0]      p;
        int             r0, r1, c0, c1, n;
        int             sum [3];
        r0 = (cr > 0) ? 0 : 1;
        r1 = (cr + 1 < h) ? 2 : 1;
        c0 = (cc > 0 && ci > 0) ? ci - 1 : ci;
        c1 = (cc + 1 < w) ? ci + 1 : ci;
        if (c1 > 2) c1 = 2;
        for (int ch = 0; ch < 3; ch++) sum[ch] = 0;
        for (int c = c0; c <= c1; c++)
        begin
            for (int r = r0; r <= r1; r++)
            begin
                p = win[c][r];
                sum[0] += p[23:16];
                sum[1] += p[15:8];
                sum[2] += p[7:0];
            end
        end
        n = (r1 - r0 + 1) * (c1 - c0 + 1);
        px.red   = 8'((2 * sum[0] + n) / (2 * n));
        px.green = 8'((2 * sum[1] + n) / (2 * n));
        px.blue  = 8'((2 * sum[2] + n) / (2 * n));
        px.eof   = (out_count == w * h - 1);
        out_count++;
        return px;
    endfunction

    function void take_request(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int             w, h, ic, ir;
        bit [23:0]      fresh, above, mid_px;
        blurred_pixel_t px;
        bit             got;
        accepted++;
        w = clamp_size(width_reg, bbn_pkg::MAX_WIDTH_DEF);
        h = clamp_size(height_reg, bbn_pkg::MAX_HEIGHT);
        if (cmd != draining) return;
        ic  = col;
        ir  = row;
        got = 1'b0;
        if (ic >= w) ic = 0;
        fresh  = cmd ? 24'd0 : {r, g, b};
        above  = upper_row[ic];
        mid_px = middle_row[ic];
        upper_row[ic]  = mid_px;
        middle_row[ic] = fresh;
        if (ic == 0 && ir >= 2)
        begin
            px  = blur_window(2, ir - 2, w - 1, w, h);
            got = 1'b1;
        end
        for (int r = 0; r < 3; r++)
        begin
            win[0][r] = win[1][r];
            win[1][r] = win[2][r];
        end
        win[2][0] = above;
        win[2][1] = mid_px;
        win[2][2] = fresh;
        if (ic > 0 && ir >= 1)
        begin
            px  = blur_window(1, ir - 1, ic - 1, w, h);
            got = 1'b1;
        end
        if (got) expected_pixels.push_back(px);
        if (got && px.eof)
        begin
            restart_frame();
            return;
        end
        if (!draining && ir == h - 1 && ic == w - 1) draining = 1'b1;
        ic++;
        if (ic >= w)
        begin
            ic = 0;
            ir++;
        end
        col = ic;
        row = ir;
    endfunction

    function void check_pixel(blurred_pixel_t seen);
        blurred_pixel_t want;
        checked++;
        if (expected_pixels.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected pixel: r=%0d g=%0d b=%0d eof=%0d",
                         seen.red, seen.green, seen.blue, seen.eof);
            return;
        end
        want = expected_pixels.pop_front();
        if (want.eof) frames++;
        if (seen.red !== want.red || seen.green !== want.green ||
            seen.blue !== want.blue || seen.eof !== want.eof)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("pixel mismatch: expected r=%0d g=%0d b=%0d eof=%0d, got r=%0d g=%0d b=%0d eof=%0d",
                         want.red, want.green, want.blue, want.eof,
                         seen.red, seen.green, seen.blue, seen.eof);
        end
    endfunction
endclass

module tb_box_blur_3x3_edge_normalized;
    import bbn_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 7;
    // settling time after the last result; allow for stalls in the pipe
    localparam int SETTLE_CYCLES   = 24;
    // random frames stop once this many frame requests went in
    localparam int RANDOM_REQUESTS = 1000;
    // hard limit, far beyond the slowest correct run
    localparam int LIMIT_CYCLES    = 1000000;

    // register indexes the block has no register behind
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // request commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum int {PH_STEADY, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH} idle_phase_e;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SIZE_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 command;
    logic [7:0]           in_red;
    logic [7:0]           in_green;
    logic [7:0]           in_blue;
    logic                 out_valid;
    logic                 out_stall;
    logic [7:0]           out_red;
    logic [7:0]           out_green;
    logic [7:0]           out_blue;
    logic                 end_of_frame;

    blur_tracker tracker;
    int          send_idle_pct;
    int          stall_pct;
    int          frame_requests;

    box_blur_3x3_edge_normalized dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .in_red       (in_red),
        .in_green     (in_green),
        .in_blue      (in_blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .end_of_frame (end_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d pixels still expected", tracker.expected_pixels.size());
        $display("tb_box_blur_3x3_edge_normalized NOT OK");
        $finish;
    end

    // result side: stall decided at the falling edge, results taken at the rising edge
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                tracker.check_pixel(blurred_pixel_t'({out_red, out_green, out_blue, end_of_frame}));
            @(negedge clk);
            out_stall = ($urandom_range(99) < stall_pct);
        end
    end

    function automatic void set_phase(idle_phase_e ph);
        case (ph)
            PH_STEADY:         begin send_idle_pct = 0;  stall_pct = 0;  end
            PH_SENDER_IDLE:    begin send_idle_pct = 67; stall_pct = 0;  end
            PH_RECEIVER_STALL: begin send_idle_pct = 0;  stall_pct = 67; end
            default:           begin send_idle_pct = 6;  stall_pct = 6;  end
        endcase
    endfunction

    // channel value biased toward black and full scale
    function automatic logic [7:0] random_level();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] random_pixel();
        return {random_level(), random_level(), random_level()};
    endfunction

    // register write, called at a falling edge while the block is idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = data;
        @(negedge clk);
        cfg_write_en = 1'b0;
        tracker.write_register(idx, data);
    endtask

    // one request: random idle cycles first, then hold until the block takes it
    task automatic send_request(input logic cmd, input logic [23:0] rgb);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            command  = 1'($urandom);
            {in_red, in_green, in_blue} = 24'($urandom);
            @(negedge clk);
        end
        in_valid = 1'b1;
        command  = cmd;
        {in_red, in_green, in_blue} = rgb;
        do @(posedge clk); while (in_stall);
        tracker.take_request(cmd, rgb[23:16], rgb[15:8], rgb[7:0]);
        @(negedge clk);
    endtask

    // drop valid, wait for every expected pixel, then let the pipe go quiet
    task automatic wait_idle();
        in_valid = 1'b0;
        while (tracker.expected_pixels.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // a whole frame plus the width + 1 flushes that drain it; noisy adds
    // stray flushes mid-frame and stray pixels while draining, both dropped
    task automatic run_frame(input int w, input int h, input bit noisy);
        int k;
        for (k = 0; k < w * h; k++)
        begin
            if (noisy && $urandom_range(99) < 4) send_request(CMD_FLUSH, 24'($urandom));
            send_request(CMD_PIXEL, random_pixel());
        end
        for (k = 0; k <= w; k++)
        begin
            if (noisy && $urandom_range(99) < 4) send_request(CMD_PIXEL, random_pixel());
            // flush payload is a don't care
            send_request(CMD_FLUSH, 24'($urandom));
        end
        // flush right after the frame end is dropped too
        if (noisy && $urandom_range(99) < 20) send_request(CMD_FLUSH, 24'($urandom));
        frame_requests += w * h + w + 1;
    endtask

    initial
    begin
        int w, h, wr, hr, setting_count, reps;
        tracker        = new();
        frame_requests = 0;
        setting_count  = 0;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_index      = CFG_FRAME_WIDTH;
        cfg_data       = '0;
        in_valid       = 1'b0;
        command        = CMD_PIXEL;
        in_red         = '0;
        in_green       = '0;
        in_blue        = '0;
        set_phase(PH_STEADY);
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // smallest frame: every output is a corner, average of 4
        cfg_write(CFG_FRAME_WIDTH, 11'd2);
        cfg_write(CFG_FRAME_HEIGHT, 11'd2);
        // writes to unused indexes must leave the sizes alone
        cfg_write(CFG_SPARE_2, '1);
        cfg_write(CFG_SPARE_3, '0);
        // flush outside draining is dropped
        send_request(CMD_FLUSH, 24'hFFFFFF);
        // green sums to 2 over 4: exact half rounds up to 1
        send_request(CMD_PIXEL, {8'hFF, 8'h01, 8'h00});
        send_request(CMD_PIXEL, {8'hFF, 8'h01, 8'hFF});
        send_request(CMD_PIXEL, {8'hFF, 8'h00, 8'h00});
        send_request(CMD_PIXEL, {8'hFF, 8'h00, 8'h01});
        send_request(CMD_FLUSH, 24'h000000);
        // pixel while draining is dropped
        send_request(CMD_PIXEL, 24'hFFFFFF);
        send_request(CMD_FLUSH, 24'hFFFFFF);
        send_request(CMD_FLUSH, 24'h5A5A5A);
        wait_idle();

        // 3x3 frame: corners over 4, edges over 6, center over 9, half steps on green
        cfg_write(CFG_FRAME_WIDTH, 11'd3);
        cfg_write(CFG_FRAME_HEIGHT, 11'd3);
        for (int k = 0; k < 9; k++)
            send_request(CMD_PIXEL, {8'hFF, (k % 2) ? 8'hFF : 8'h00, 8'(k * 31)});
        for (int k = 0; k < 4; k++)
            send_request(CMD_FLUSH, 24'($urandom));

        // random small frames, idling mode rotating per size setting
        while (frame_requests < RANDOM_REQUESTS)
        begin
            wait_idle();
            set_phase(idle_phase_e'(setting_count % 4));
            w  = ($urandom_range(3) == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
            h  = $urandom_range(2, 6);
            wr = w;
            hr = h;
            // sizes below two read as two
            if ($urandom_range(9) == 0)
            begin
                w  = 2;
                wr = $urandom_range(1);
            end
            if ($urandom_range(9) == 0)
            begin
                h  = 2;
                hr = $urandom_range(1);
            end
            if ($urandom_range(1))
            begin
                cfg_write(CFG_FRAME_WIDTH, 11'(wr));
                cfg_write(CFG_FRAME_HEIGHT, 11'(hr));
            end
            else
            begin
                cfg_write(CFG_FRAME_HEIGHT, 11'(hr));
                cfg_write(CFG_FRAME_WIDTH, 11'(wr));
            end
            reps = $urandom_range(1, 3);
            while (reps > 0 && frame_requests < RANDOM_REQUESTS)
            begin
                run_frame(w, h, 1'b1);
                reps--;
            end
            setting_count++;
        end

        wait_idle();
        $display("blurred %0d pixels over %0d frames from %0d accepted requests",
                 tracker.checked, tracker.frames, tracker.accepted);
        $display("sizes from 2x2 up to 40x6, size registers below two, dropped requests");
        if (tracker.mismatches == 0 && tracker.expected_pixels.size() == 0)
        begin
            $display("tb_box_blur_3x3_edge_normalized OK");
        end
        else
        begin
            $display("%0d mismatches, %0d pixels never seen",
                     tracker.mismatches, tracker.expected_pixels.size());
            $display("tb_box_blur_3x3_edge_normalized NOT OK");
        end
        $finish;
    end
endmodule
